// File: rtl/core/amp_pkg.sv
// Package: shared widths, codes and command types of the approximate pattern matcher.
`default_nettype none
package amp_pkg;

	// Defaults for the top-level parameters
	localparam int NUM_PATTERNS_DEF = 8;
	localparam int MAX_ERRORS_DEF   = 7;
	localparam int PATTERN_BITS_DEF = 64;

	// Fixed symbol count and field widths
	localparam int NUM_SYMBOLS   = 256;
	localparam int SYM_W         = 8;
	localparam int MODE_W        = 2;
	localparam int PIDX_W        = 3;
	localparam int POS_W         = 6;
	localparam int ERRL_W        = 3;
	localparam int PIU_W         = 4;
	localparam int FLAGS_W       = 8;
	localparam int MATCH_CNT_W   = 4;
	localparam int TOTAL_W       = 32;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 4;

	// Item modes; the fourth code is unused and behaves as a load that changes nothing
	typedef enum logic [MODE_W-1:0] {
		MODE_TEXT  = 2'd0,
		MODE_LOAD  = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERNS_IN_USE = 1'b1;

	// Command broadcast from the top level to every pattern lane
	typedef struct packed {
		logic              text_step;
		logic              first;
		logic              load;
		logic              clear;
		logic [POS_W-1:0]  pos;
		logic [ERRL_W-1:0] k;
	} lane_cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/amp_if.sv
// Interfaces: item, result and configuration channels of the pattern matcher.
`default_nettype none
interface amp_item_if;
	import amp_pkg::*;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [SYM_W-1:0]  symbol;
	logic [PIDX_W-1:0] pattern_index;
	logic [POS_W-1:0]  position;
	logic              first_of_text;
	logic              last_of_text;
	modport source (output valid, mode, symbol, pattern_index, position, first_of_text,
		last_of_text, input ready);
	modport sink (input valid, mode, symbol, pattern_index, position, first_of_text,
		last_of_text, output ready);
endinterface

interface amp_result_if;
	import amp_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [FLAGS_W-1:0]     match_flags;
	logic [MATCH_CNT_W-1:0] matches_here;
	logic [TOTAL_W-1:0]     total_matches;
	logic                   end_of_text;
	modport source (output valid, match_flags, matches_here, total_matches, end_of_text,
		input ready);
	modport sink (input valid, match_flags, matches_here, total_matches, end_of_text,
		output ready);
endinterface

interface amp_cfg_if;
	import amp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/amp_mask_bank.sv
// Mask bank: per-symbol mask words of one pattern, bit-clear writes and registered read.
`default_nettype none
module amp_mask_bank #(
	parameter int PATTERN_BITS = amp_pkg::PATTERN_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [amp_pkg::SYM_W-1:0] rd_addr,
	output logic      [PATTERN_BITS-1:0]  rd_data,
	input  wire logic                     fill_en,
	input  wire logic [amp_pkg::SYM_W-1:0] fill_addr,
	input  wire logic                     bit_en,
	input  wire logic [amp_pkg::SYM_W-1:0] bit_addr,
	input  wire logic [$clog2(PATTERN_BITS)-1:0] bit_idx
);
	import amp_pkg::*;

	logic [PATTERN_BITS-1:0] mem [NUM_SYMBOLS];
	logic [SYM_W-1:0]        waddr;
	logic [PATTERN_BITS-1:0] wdata;
	logic [PATTERN_BITS-1:0] wbe;

	// Fill writes a whole word of ones; a load clears a single bit
	always_comb begin
		if (fill_en) begin
			waddr = fill_addr;
			wdata = '1;
			wbe   = '1;
		end else begin
			waddr = bit_addr;
			wdata = '0;
			wbe   = bit_en ? ({{(PATTERN_BITS-1){1'b0}}, 1'b1} << bit_idx) : '0;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < PATTERN_BITS; j++) begin
			if (wbe[j]) mem[waddr][j] <= wdata[j];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// File: rtl/core/amp_lane.sv
// Pattern lane: length register, error-level vector chain and match detect of one pattern.
`default_nettype none
module amp_lane #(
	parameter int PATTERN_BITS = amp_pkg::PATTERN_BITS_DEF,
	parameter int MAX_ERRORS   = amp_pkg::MAX_ERRORS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire amp_pkg::lane_cmd_t      cmd,
	input  wire logic                    lane_sel,
	input  wire logic                    lane_used,
	input  wire logic [PATTERN_BITS-1:0] cm,
	output logic                         hit
);
	import amp_pkg::*;

	localparam int LEVELS = MAX_ERRORS + 1;
	localparam int LEN_W  = $clog2(PATTERN_BITS + 1);

	logic [LEN_W-1:0]        len_q;
	logic [PATTERN_BITS-1:0] vec_q [LEVELS];
	logic [PATTERN_BITS-1:0] base  [LEVELS];
	logic [PATTERN_BITS-1:0] nxt   [LEVELS];
	logic [PATTERN_BITS-1:0] sel_vec;
	logic [PATTERN_BITS-1:0] top;
	logic [POS_W:0]          pos_inc;
	logic [LEN_W-1:0]        new_len;
	logic                    live;

	assign pos_inc = {1'b0, cmd.pos} + {{POS_W{1'b0}}, 1'b1};
	assign new_len = pos_inc[LEN_W-1:0];
	assign live    = lane_used && (len_q != '0);

	// Error chain: each level uses the old and new vectors of the level below
	always_comb begin
		for (int q = 0; q < LEVELS; q++) begin
			base[q] = cmd.first ? ({PATTERN_BITS{1'b1}} << q) : vec_q[q];
		end
		nxt[0] = (base[0] << 1) | cm;
		for (int q = 1; q < LEVELS; q++) begin
			nxt[q] = ((base[q] << 1) | cm) & (base[q-1] << 1) & (nxt[q-1] << 1) & base[q-1];
		end
		sel_vec = '0;
		for (int q = 0; q < LEVELS; q++) begin
			if (4'(q) == {1'b0, cmd.k}) sel_vec = nxt[q];
		end
		top = {{(PATTERN_BITS-1){1'b0}}, 1'b1} << (len_q - LEN_W'(1));
		hit = cmd.text_step && live && ((sel_vec & top) == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.clear && lane_sel) begin
			len_q <= '0;
		end else if (cmd.load && lane_sel && (len_q < new_len)) begin
			len_q <= new_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < LEVELS; q++) vec_q[q] <= {PATTERN_BITS{1'b1}} << q;
		end else if (cmd.text_step) begin
			for (int q = 0; q < LEVELS; q++) vec_q[q] <= live ? nxt[q] : base[q];
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/approximate_multi_pattern_matcher_core.sv
// Top level: approximate multi-pattern matcher, k-error shift-or over several patterns.
// Each item passes the input stage register and then the result register.
// Throughput: one item per cycle for text bytes and loads while results are taken;
//   every pattern's error chain advances in the single stage between those two registers.
// A clear item holds item.ready low while its mask bank refills with ones.
// Reset (arst_n low, asynchronous) clears control state, lengths and total, presets vectors;
//   a fill of all mask banks follows, with item.ready low and cfg taken.
`default_nettype none
module approximate_multi_pattern_matcher_core #(
	parameter int NUM_PATTERNS = amp_pkg::NUM_PATTERNS_DEF,
	parameter int MAX_ERRORS   = amp_pkg::MAX_ERRORS_DEF,
	parameter int PATTERN_BITS = amp_pkg::PATTERN_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	amp_item_if.sink     item,
	amp_result_if.source result,
	amp_cfg_if.sink      cfg
);
	import amp_pkg::*;

	localparam int BIT_W = $clog2(PATTERN_BITS);
	localparam int CNT_W = $clog2(NUM_PATTERNS + 1);

	// Configuration registers
	logic [ERRL_W-1:0] error_limit_q;
	logic [PIU_W-1:0]  patterns_in_use_q;

	// Mask fill sweep (after reset and for clear items)
	logic                    sweep_active_q;
	logic [SYM_W-1:0]        sweep_addr_q;
	logic [NUM_PATTERNS-1:0] sweep_banks_q;
	logic [NUM_PATTERNS-1:0] clear_banks;

	// Input stage
	logic              valid_s1;
	logic [MODE_W-1:0] mode_s1;
	logic [PIDX_W-1:0] pidx_s1;
	logic [POS_W-1:0]  pos_s1;
	logic              pos_ok_s1;
	logic              first_s1;
	logic              last_s1;

	// Result register and running total
	logic                   out_valid_q;
	logic [FLAGS_W-1:0]     flags_q;
	logic [MATCH_CNT_W-1:0] count_q;
	logic [TOTAL_W-1:0]     total_q;
	logic                   eot_q;
	logic [TOTAL_W-1:0]     run_total_q;

	logic accept;
	logic s1_adv;
	logic in_pos_ok;
	logic is_text;

	logic [PATTERN_BITS-1:0]   cm   [NUM_PATTERNS];
	logic [NUM_PATTERNS-1:0]   hits;
	logic [NUM_PATTERNS+7:0]   hits_wide;
	logic [CNT_W-1:0]          count;
	logic [TOTAL_W-1:0]        base_total;
	logic [TOTAL_W:0]          sum_total;
	logic [TOTAL_W-1:0]        new_total;
	logic [ERRL_W-1:0]         k_eff;
	lane_cmd_t                 cmd;

	// Advance the input stage when the result register is free or draining
	assign s1_adv     = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !sweep_active_q && (!valid_s1 || s1_adv);
	assign accept     = item.valid && item.ready;
	assign in_pos_ok  = 32'(item.position) < PATTERN_BITS;
	assign is_text    = (mode_s1 == MODE_TEXT);

	// Configuration port: always ready; to be written only while idle, not enforced by the block
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_limit_q     <= '0;
			patterns_in_use_q <= PIU_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_ERROR_LIMIT:     error_limit_q     <= cfg.data[ERRL_W-1:0];
				CFG_PATTERNS_IN_USE: patterns_in_use_q <= cfg.data[PIU_W-1:0];
			endcase
		end
	end

	assign k_eff = (32'(error_limit_q) > MAX_ERRORS) ? ERRL_W'(MAX_ERRORS) : error_limit_q;

	// Banks addressed by a clear item; an index beyond the pattern count selects none
	always_comb begin
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			clear_banks[p] = ({2'b0, item.pattern_index} == 5'(p));
		end
	end

	// Sweep: refill the chosen banks with ones, one symbol row per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_active_q <= 1'b1;
			sweep_addr_q   <= '0;
			sweep_banks_q  <= '1;
		end else if (sweep_active_q) begin
			sweep_addr_q <= sweep_addr_q + SYM_W'(1);
			if (sweep_addr_q == '1) sweep_active_q <= 1'b0;
		end else if (accept && (item.mode == MODE_CLEAR) && (|clear_banks)) begin
			sweep_active_q <= 1'b1;
			sweep_addr_q   <= '0;
			sweep_banks_q  <= clear_banks;
		end
	end

	// Input stage: hold the item while its mask words are read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1   <= item.mode;
			pidx_s1   <= item.pattern_index;
			pos_s1    <= item.position;
			pos_ok_s1 <= in_pos_ok;
			first_s1  <= item.first_of_text;
			last_s1   <= item.last_of_text;
		end
	end

	// Command for the lanes; lengths and vectors change when the item leaves the stage
	always_comb begin
		cmd.text_step = s1_adv && is_text;
		cmd.first     = first_s1;
		cmd.load      = s1_adv && (mode_s1 == MODE_LOAD) && pos_ok_s1;
		cmd.clear     = s1_adv && (mode_s1 == MODE_CLEAR);
		cmd.pos       = pos_s1;
		cmd.k         = k_eff;
	end

	for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_pat
		logic bit_en;
		logic sel;
		logic used;

		// Mask bits are cleared on acceptance, so the next text byte already sees them
		assign bit_en = accept && (item.mode == MODE_LOAD) && in_pos_ok
			&& ({2'b0, item.pattern_index} == 5'(p));
		assign sel    = ({2'b0, pidx_s1} == 5'(p));
		assign used   = ({1'b0, patterns_in_use_q} > 5'(p));

		amp_mask_bank #(
			.PATTERN_BITS (PATTERN_BITS)
		) u_bank (
			.clk       (clk),
			.rd_en     (accept),
			.rd_addr   (item.symbol),
			.rd_data   (cm[p]),
			.fill_en   (sweep_active_q && sweep_banks_q[p]),
			.fill_addr (sweep_addr_q),
			.bit_en    (bit_en),
			.bit_addr  (item.symbol),
			.bit_idx   (item.position[BIT_W-1:0])
		);

		amp_lane #(
			.PATTERN_BITS (PATTERN_BITS),
			.MAX_ERRORS   (MAX_ERRORS)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.lane_sel  (sel),
			.lane_used (used),
			.cm        (cm[p]),
			.hit       (hits[p])
		);
	end

	// Count matching patterns and add to the total, saturating at the top
	always_comb begin
		count = '0;
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			count = count + CNT_W'(hits[p]);
		end
		base_total = first_s1 ? '0 : run_total_q;
		sum_total  = {1'b0, base_total} + (TOTAL_W + 1)'(count);
		new_total  = sum_total[TOTAL_W] ? '1 : sum_total[TOTAL_W-1:0];
	end

	assign hits_wide = {8'b0, hits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_total_q <= '0;
		end else if (s1_adv && is_text) begin
			run_total_q <= new_total;
		end
	end

	// Result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			if (is_text) begin
				flags_q <= hits_wide[FLAGS_W-1:0];
				count_q <= MATCH_CNT_W'(count);
				total_q <= new_total;
				eot_q   <= last_s1;
			end else begin
				flags_q <= '0;
				count_q <= '0;
				total_q <= run_total_q;
				eot_q   <= 1'b0;
			end
		end
	end

	assign result.valid         = out_valid_q;
	assign result.match_flags   = flags_q;
	assign result.matches_here  = count_q;
	assign result.total_matches = total_q;
	assign result.end_of_text   = eot_q;

endmodule
`default_nettype wire

// File: rtl/core/amp_checker.sv
// Checker: port-level assertions for the matcher core, bound to the top level.
`default_nettype none
module amp_checker #(
	parameter int NUM_PATTERNS = amp_pkg::NUM_PATTERNS_DEF
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_ready,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic [amp_pkg::FLAGS_W-1:0]     match_flags,
	input wire logic [amp_pkg::MATCH_CNT_W-1:0] matches_here,
	input wire logic [amp_pkg::TOTAL_W-1:0]     total_matches
);
	import amp_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_matches)
			&& $stable(match_flags) && $stable(matches_here))
		else $error("stalled result changed");

	// Block items at the start of the fill that follows reset
	a_fill_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !in_ready)
		else $error("item accepted during post-reset fill");

	// Count agrees with the flags when every pattern has a flag bit
	a_count_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (NUM_PATTERNS > FLAGS_W) || (32'(matches_here) == $countones(match_flags)))
		else $error("match count disagrees with flags");

	// Never report more matching patterns than exist, checked when there are at most 15
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (NUM_PATTERNS > 15) || (32'(matches_here) <= NUM_PATTERNS))
		else $error("match count out of range");

endmodule

bind approximate_multi_pattern_matcher_core amp_checker #(
	.NUM_PATTERNS (NUM_PATTERNS)
) u_amp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (item.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.match_flags   (result.match_flags),
	.matches_here  (result.matches_here),
	.total_matches (result.total_matches)
);
`default_nettype wire
